// ----- src/crce_pkg.sv -----
// Package for the configurable CRC engine: shared types, codes and bit helpers.
`default_nettype none

package crce_pkg;

    // Width codes; any other code behaves as 32 bits
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_WIDTH_MODE = 3'd0;
    localparam logic [2:0] REG_POLYNOMIAL = 3'd1;
    localparam logic [2:0] REG_INIT_VALUE = 3'd2;
    localparam logic [2:0] REG_XOR_OUT    = 3'd3;
    localparam logic [2:0] REG_REFLECT    = 3'd4;

    // Reset values of the configuration registers (CRC-32)
    localparam logic [1:0]  RST_WIDTH_MODE = WIDTH_32;
    localparam logic [31:0] RST_POLYNOMIAL = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INIT_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_XOR_OUT    = 32'hFFFF_FFFF;
    localparam logic        RST_REFLECT    = 1'b1;

    typedef struct packed {
        logic [1:0]  width_mode;
        logic [31:0] polynomial;
        logic [31:0] init_value;
        logic [31:0] xor_out;
        logic        reflect;
    } t_cfg;

    // Mask of the active CRC bits
    function automatic logic [31:0] f_mask(input logic [1:0] width_mode);
        logic [31:0] m;
        begin
            case (width_mode)
                WIDTH_8:  m = 32'h0000_00FF;
                WIDTH_16: m = 32'h0000_FFFF;
                default:  m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // Full 32-bit bit reversal
    function automatic logic [31:0] f_reverse32(input logic [31:0] v);
        logic [31:0] r;
        begin
            for (int i = 0; i < 32; i++) begin
                r[i] = v[31 - i];
            end
            return r;
        end
    endfunction

    // Mirror the low W bits of a value (upper bits must be zero)
    function automatic logic [31:0] f_mirror(input logic [31:0] v,
                                             input logic [1:0]  width_mode);
        logic [31:0] r;
        logic [31:0] m;
        begin
            r = f_reverse32(v);
            case (width_mode)
                WIDTH_8:  m = r >> 24;
                WIDTH_16: m = r >> 16;
                default:  m = r;
            endcase
            return m;
        end
    endfunction

    // Byte order reversal of the result for 16 and 32 bit widths
    function automatic logic [31:0] f_byte_swap(input logic [31:0] v,
                                                input logic [1:0]  width_mode);
        logic [31:0] s;
        begin
            case (width_mode)
                WIDTH_8:  s = v;
                WIDTH_16: s = {16'h0000, v[7:0], v[15:8]};
                default:  s = {v[7:0], v[15:8], v[23:16], v[31:24]};
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/crce_cfg_regs.sv -----
// Configuration register bank of the CRC engine with write-triggered reload flag.
`default_nettype none

module crce_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    output crce_pkg::t_cfg           o_cfg,
    output logic                     o_cfg_hit
);

    crce_pkg::t_cfg r_cfg;
    crce_pkg::t_cfg n_cfg;
    logic           hit;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        hit   = 1'b0;
        if (i_cfg_we) begin
            hit = 1'b1;
            case (i_cfg_index)
                crce_pkg::REG_WIDTH_MODE: n_cfg.width_mode = i_cfg_data[1:0];
                crce_pkg::REG_POLYNOMIAL: n_cfg.polynomial = i_cfg_data;
                crce_pkg::REG_INIT_VALUE: n_cfg.init_value = i_cfg_data;
                crce_pkg::REG_XOR_OUT:    n_cfg.xor_out    = i_cfg_data;
                crce_pkg::REG_REFLECT:    n_cfg.reflect    = i_cfg_data[0];
                default:                  hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode <= crce_pkg::RST_WIDTH_MODE;
            r_cfg.polynomial <= crce_pkg::RST_POLYNOMIAL;
            r_cfg.init_value <= crce_pkg::RST_INIT_VALUE;
            r_cfg.xor_out    <= crce_pkg::RST_XOR_OUT;
            r_cfg.reflect    <= crce_pkg::RST_REFLECT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_cfg_hit = hit;

endmodule

`default_nettype wire

// ----- src/crce_update.sv -----
// Combinational byte-wide CRC update and result formatting.
`default_nettype none

module crce_update (
    input  wire crce_pkg::t_cfg  i_cfg,
    input  wire logic            i_start,
    input  wire logic [31:0]     i_crc,
    input  wire logic [7:0]      i_data_byte,
    output logic [31:0]          o_crc_next,
    output logic [31:0]          o_crc_result
);

    logic [31:0] mask;
    logic [31:0] poly;
    logic [31:0] rpoly;
    logic [31:0] crc_in;
    logic [31:0] crc;
    logic [31:0] crc_masked;
    logic        top_bit;

    always_comb begin
        mask   = crce_pkg::f_mask(i_cfg.width_mode);
        poly   = i_cfg.polynomial & mask;
        rpoly  = crce_pkg::f_mirror(poly, i_cfg.width_mode);
        // A new message starts from the init value
        crc_in = (i_start ? i_cfg.init_value : i_crc) & mask;
        crc    = crc_in;
        top_bit = 1'b0;

        if (i_cfg.reflect) begin
            // LSB first: right shift with mirrored polynomial
            crc = crc ^ {24'h000000, i_data_byte};
            for (int i = 0; i < 8; i++) begin
                crc = crc[0] ? ((crc >> 1) ^ rpoly) : (crc >> 1);
            end
        end else begin
            // MSB first: byte aligned under the top of the register
            case (i_cfg.width_mode)
                crce_pkg::WIDTH_8:  crc = crc ^ {24'h000000, i_data_byte};
                crce_pkg::WIDTH_16: crc = crc ^ {16'h0000, i_data_byte, 8'h00};
                default:            crc = crc ^ {i_data_byte, 24'h000000};
            endcase
            for (int i = 0; i < 8; i++) begin
                case (i_cfg.width_mode)
                    crce_pkg::WIDTH_8:  top_bit = crc[7];
                    crce_pkg::WIDTH_16: top_bit = crc[15];
                    default:            top_bit = crc[31];
                endcase
                crc = top_bit ? ((crc << 1) ^ poly) : (crc << 1);
            end
        end

        crc_masked   = crc & mask;
        o_crc_next   = crc_masked;
        o_crc_result = crce_pkg::f_byte_swap((crc_masked ^ i_cfg.xor_out) & mask,
                                             i_cfg.width_mode);
    end

endmodule

`default_nettype wire

// ----- src/configurable_crc_engine_top.sv -----
// Top level of the configurable CRC-8/16/32 engine.
// Flow: a byte accepted into the input register updates the running CRC register as it
// leaves; a last byte also loads the result register and waits while it is held.
// Throughput: one byte per cycle except such waits, set by the unrolled 8-bit update.
// Reset: synchronous active-low; CRC-32 configuration restored, next byte uses init.
`default_nettype none

module configurable_crc_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_crc_result
);

    crce_pkg::t_cfg cfg;
    logic           cfg_hit;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_start;
    logic [31:0] r_crc;
    logic        r_out_valid;
    logic [31:0] r_out_crc;

    logic        out_free;
    logic        fire;
    logic        in_take;
    logic [31:0] crc_next;
    logic [31:0] crc_result;

    crce_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_hit   (cfg_hit)
    );

    crce_update u_update (
        .i_cfg        (cfg),
        .i_start      (r_start),
        .i_crc        (r_crc),
        .i_data_byte  (r_in_byte),
        .o_crc_next   (crc_next),
        .o_crc_result (crc_result)
    );

    // Handshake: a byte leaves the input register unless it carries a result
    // and the output register is still held
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_in_last || out_free);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Running CRC; r_start marks that the next byte begins a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
        end else if (cfg_hit) begin
            r_start <= 1'b1;
        end else if (fire) begin
            r_start <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_crc <= crc_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out_crc <= crc_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_crc_result = r_out_crc;

endmodule

`default_nettype wire

// ----- tb/sv/tb_configurable_crc_engine_top.sv -----
// Self-checking testbench for the configurable CRC-8/16/32 engine.
`timescale 1ns / 1ps

module tb_configurable_crc_engine_top;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_ITEMS    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int SEG_ITEMS      = 150;
    localparam int SEGS_PER_PHASE = 3;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // One directed stimulus row: a byte transaction or a register write
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  index;
        logic [31:0] value;
        logic        last;
        logic        known;
        logic [31:0] answer;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_out_stall;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [31:0] o_crc_result;

    // Known answer travels with the byte it belongs to
    logic        item_known;
    logic [31:0] item_answer;

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    logic hold_start   = 1'b0;
    int hold_left      = 0;

    // Shadow of the block: configuration and running CRC
    crce_pkg::t_cfg cfg_shadow;
    logic [31:0]    crc_shadow;
    logic [31:0]    pending_crc_q[$];
    t_dir_row       dir_rows[$];

    int fail_count   = 0;
    int report_count = 0;
    int quiet_cycles = 0;
    int bytes_in     = 0;
    int crcs_out     = 0;
    int cfg_writes   = 0;

    configurable_crc_engine_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_crc_result (o_crc_result)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int unsigned crc_bits_of(input logic [1:0] wm);
        case (wm)
            crce_pkg::WIDTH_8:  return 8;
            crce_pkg::WIDTH_16: return 16;
            default:            return 32;
        endcase
    endfunction

    function automatic logic [31:0] width_mask(input int unsigned w);
        return (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
    endfunction

    // Register write as the block sees it; bad indexes leave everything alone
    function automatic void apply_cfg(input logic [2:0] idx, input logic [31:0] d);
        case (idx)
            crce_pkg::REG_WIDTH_MODE: cfg_shadow.width_mode = d[1:0];
            crce_pkg::REG_POLYNOMIAL: cfg_shadow.polynomial = d;
            crce_pkg::REG_INIT_VALUE: cfg_shadow.init_value = d;
            crce_pkg::REG_XOR_OUT:    cfg_shadow.xor_out    = d;
            crce_pkg::REG_REFLECT:    cfg_shadow.reflect    = d[0];
            default:                  return;
        endcase
        crc_shadow = cfg_shadow.init_value & width_mask(crc_bits_of(cfg_shadow.width_mode));
    endfunction

    // Advance the CRC by one byte; on the last byte return the final CRC
    function automatic logic crc_advance(input logic [7:0] b, input logic l,
                                         output logic [31:0] res);
        int unsigned w;
        logic [31:0] m;
        logic [31:0] p;
        logic [31:0] rp;
        logic [31:0] top;
        logic [31:0] c;
        logic [31:0] x;
        w   = crc_bits_of(cfg_shadow.width_mode);
        m   = width_mask(w);
        p   = cfg_shadow.polynomial & m;
        c   = crc_shadow & m;
        res = '0;
        if (cfg_shadow.reflect) begin
            rp = '0;
            for (int i = 0; i < w; i++) rp[w - 1 - i] = p[i];
            c ^= {24'h0, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
        end else begin
            top = 32'h1 << (w - 1);
            c ^= {24'h0, b} << (w - 8);
            repeat (8) c = ((c & top) != 0) ? ((c << 1) ^ p) : (c << 1);
        end
        c = c & m;
        crc_shadow = c;
        if (!l) return 1'b0;
        x = (c ^ cfg_shadow.xor_out) & m;
        case (w)
            16:      res = {16'h0, x[7:0], x[15:8]};
            32:      res = {x[7:0], x[15:8], x[23:16], x[31:24]};
            default: res = x;
        endcase
        crc_shadow = cfg_shadow.init_value & m;
        return 1'b1;
    endfunction

    function automatic void add_row(input t_row_kind k, input logic [2:0] idx,
                                    input logic [31:0] v, input logic l,
                                    input logic kn, input logic [31:0] ans);
        t_dir_row r;
        r.kind   = k;
        r.index  = idx;
        r.value  = v;
        r.last   = l;
        r.known  = kn;
        r.answer = ans;
        dir_rows.push_back(r);
    endfunction

    // Check results, track register writes and predict on accepted bytes
    always @(posedge i_clk) begin
        logic [31:0] predicted;
        logic [31:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                crcs_out++;
                if (pending_crc_q.size() == 0) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display("ERROR: unexpected CRC %08h at %0t", o_crc_result, $realtime);
                    report_count++;
                end else begin
                    want = pending_crc_q.pop_front();
                    if (o_crc_result !== want) begin
                        fail_count++;
                        if (report_count < MAX_REPORTS)
                            $display("ERROR: crc_result expected %08h got %08h at %0t",
                                     want, o_crc_result, $realtime);
                        report_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                cfg_writes++;
                apply_cfg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                bytes_in++;
                if (crc_advance(i_data_byte, i_last_byte, predicted))
                    pending_crc_q.push_back(item_known ? item_answer : predicted);
            end
        end
    end

    // Receiver: random stalls, plus a long hold counted here
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l,
                             input logic kn, input logic [31:0] ans);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        item_known  <= kn;
        item_answer <= ans;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait until every CRC is out and the block is quiet
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_crc_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random setting: all five registers in a rotated order, unused bits random
    task automatic program_random_cfg();
        int first;
        logic [2:0] idx;
        logic [31:0] d;
        wait_drained();
        first = $urandom_range(0, 4);
        for (int k = 0; k < 5; k++) begin
            idx = 3'((first + k) % 5);
            case (idx)
                crce_pkg::REG_WIDTH_MODE:
                    d = ($urandom & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3));
                crce_pkg::REG_POLYNOMIAL: begin
                    case ($urandom_range(0, 7))
                        0:       d = crce_pkg::RST_POLYNOMIAL;
                        1:       d = 32'h0000_1021;
                        2:       d = 32'h0000_8005;
                        3:       d = 32'h0000_0007;
                        4:       d = 32'h1EDC_6F41;
                        default: d = pick_word();
                    endcase
                end
                crce_pkg::REG_REFLECT: d = $urandom;
                default:               d = pick_word();
            endcase
            cfg_write(idx, d);
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(crce_pkg::REG_REFLECT + 3'($urandom_range(1, 3)), $urandom);
    endtask

    // Messages of random length; now and then an ignored write mid-message
    // or a message left open for the next setting to drop
    task automatic send_messages(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
                if (j == len / 2 && len > 1 && $urandom_range(0, 19) == 0) begin
                    wait_drained();
                    cfg_write(crce_pkg::REG_REFLECT + 3'($urandom_range(1, 3)), $urandom);
                end
                send_byte(8'($urandom), j == len - 1, 1'b0, '0);
            end
            sent += len;
        end
        if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_out_stall = 1'b0;
        item_known  = 1'b0;
        item_answer = '0;
        cfg_shadow  = '{crce_pkg::RST_WIDTH_MODE, crce_pkg::RST_POLYNOMIAL,
                        crce_pkg::RST_INIT_VALUE, crce_pkg::RST_XOR_OUT,
                        crce_pkg::RST_REFLECT};
        crc_shadow  = crce_pkg::RST_INIT_VALUE;

        // CRC-32 check string after reset
        for (int j = 0; j < 9; j++)
            add_row(ROW_BYTE, '0, 32'h31 + j, j == 8, j == 8, 32'h2639_F4CB);
        // CRC-8 with junk in every unused bit
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'hFFFF_FFFC, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'hABCD_EF07, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h5A5A_5A00, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT,    32'h1234_5600, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_REFLECT,    32'hFFFF_FFFE, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h00, 1'b1, 1'b1, 32'h0000_0000);
        add_row(ROW_BYTE, '0, 32'hFF, 1'b1, 1'b0, '0);
        // unused width code acts as 32 bits; zero polynomial only shifts
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'h0000_0003, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h1234_5678, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT,    32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h9A, 1'b1, 1'b1, 32'h0078_5634);
        // 16 bit reflected; a bad index mid-message keeps the message
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'(crce_pkg::WIDTH_16), 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'h0000_8005, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_REFLECT,    32'h0000_0001, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_REFLECT + 3'd3, 32'hDEAD_BEEF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h00, 1'b1, 1'b0, '0);
        // a valid write mid-message drops it
        add_row(ROW_BYTE, '0, 32'h55, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT, 32'h0000_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'hAA, 1'b1, 1'b0, '0);
        // 8 bit reflected, all-ones settings
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'(crce_pkg::WIDTH_8), 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'h0000_00FF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h0000_00FF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT,    32'h0000_00FF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h80, 1'b1, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h01, 1'b1, 1'b0, '0);
        // 16 bit MSB first
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'(crce_pkg::WIDTH_16), 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'h0000_1021, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h0000_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT,    32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_REFLECT,    32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'hFF, 1'b1, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h00, 1'b1, 1'b0, '0);
        // 32 bit MSB first, all-ones polynomial; zero register gives xor_out
        add_row(ROW_CFG, crce_pkg::REG_WIDTH_MODE, 32'(crce_pkg::WIDTH_32), 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_POLYNOMIAL, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_INIT_VALUE, 32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_XOR_OUT,    32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, crce_pkg::REG_REFLECT + 3'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, '0, 32'h00, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(ROW_BYTE, '0, 32'hFF, 1'b1, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_drained();
                cfg_write(dir_rows[r].index, dir_rows[r].value);
            end else begin
                send_byte(dir_rows[r].value[7:0], dir_rows[r].last,
                          dir_rows[r].known, dir_rows[r].answer);
            end
        end

        // Random messages over four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_idle_pct = 61; sink_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin send_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            for (int s = 0; s < SEGS_PER_PHASE; s++) begin
                program_random_cfg();
                send_messages(SEG_ITEMS);
            end
            if (ph == 0) begin
                // long receiver hold while the sender keeps pushing
                wait_drained();
                @(posedge i_clk);
                hold_start = 1'b1;
                for (int j = 0; j < BURST_ITEMS; j++)
                    send_byte(8'($urandom), 1'b1, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_crc_q.size() != 0) begin
            $display("ERROR: %0d CRC results never arrived", pending_crc_q.size());
            fail_count += pending_crc_q.size();
        end
        $display("Run: %0d bytes, %0d CRC results, %0d register writes", bytes_in, crcs_out,
                 cfg_writes);
        $display("Widths 8/16/32 both bit orders, dropped messages, stall mixes; %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
